[rtl/gb3_pkg.sv]
// Shared types and constants of the 3x3 Gaussian blur unit.
`default_nettype none
package gb3_pkg;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned BLUR_W      = 16;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned OUTCOL_W    = 10;
  localparam int unsigned IMG_W_W     = 11;
  localparam int unsigned IMG_H_W     = 12;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned SUM_W       = PIXEL_W + 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned TDATA_OUT_W = ((BLUR_W + ROW_W + OUTCOL_W + 7) / 8) * 8;
  localparam int unsigned TDATA_PAD_W = TDATA_OUT_W - BLUR_W - ROW_W - OUTCOL_W;

  localparam int unsigned DIM_MIN       = 3;
  localparam int unsigned WIDTH_RESET   = 1024;
  localparam int unsigned HEIGHT_RESET  = 1024;
  localparam int unsigned WCENTER_RESET = 13380;
  localparam int unsigned WSIDE_RESET   = 8116;
  localparam int unsigned WCORNER_RESET = 4922;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_WEIGHT_CENTER = 3'd2,
    CFG_WEIGHT_SIDE   = 3'd3,
    CFG_WEIGHT_CORNER = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] center;
    logic [WEIGHT_W-1:0] side;
    logic [WEIGHT_W-1:0] corner;
  } weights_t;

  typedef struct packed {
    logic                last;
    logic [ROW_W-1:0]    row;
    logic [OUTCOL_W-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic [PIXEL_W-1:0] center;
    logic [SUM_W-1:0]   sides;
    logic [SUM_W-1:0]   corners;
  } sums_t;

endpackage
`default_nettype wire

[rtl/gb3_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gb3_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/gb3_cfg.sv]
// Configuration registers with clamping of the frame size.
`default_nettype none
module gb3_cfg #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned WidthW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gb3_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [gb3_pkg::WEIGHT_W-1:0]        cfg_data_i,
  output logic [WidthW-1:0]                   eff_width_o,
  output logic [gb3_pkg::IMG_H_W-1:0]         eff_height_o,
  output gb3_pkg::weights_t                   weights_o
);
  import gb3_pkg::*;

  localparam int unsigned ClampW = (WidthW > IMG_W_W) ? WidthW : IMG_W_W;
  localparam int unsigned WidthResetEff = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [WidthW-1:0]  width_q, width_d;
  logic [IMG_H_W-1:0] height_q, height_d;
  weights_t           weights_q, weights_d;
  logic [ClampW-1:0]  width_raw;
  logic [IMG_H_W-1:0] height_raw;

  assign cfg_ready_o = 1'b1;
  assign width_raw   = ClampW'(cfg_data_i[IMG_W_W-1:0]);
  assign height_raw  = cfg_data_i[IMG_H_W-1:0];

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    weights_d = weights_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH: begin
          if (width_raw < ClampW'(DIM_MIN)) begin
            width_d = WidthW'(DIM_MIN);
          end else if (width_raw > ClampW'(MAX_WIDTH)) begin
            width_d = WidthW'(MAX_WIDTH);
          end else begin
            width_d = WidthW'(width_raw);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          height_d = (height_raw < IMG_H_W'(DIM_MIN)) ? IMG_H_W'(DIM_MIN) : height_raw;
        end
        CFG_WEIGHT_CENTER: weights_d.center = cfg_data_i;
        CFG_WEIGHT_SIDE:   weights_d.side   = cfg_data_i;
        CFG_WEIGHT_CORNER: weights_d.corner = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q          <= WidthW'(WidthResetEff);
      height_q         <= IMG_H_W'(HEIGHT_RESET);
      weights_q.center <= WEIGHT_W'(WCENTER_RESET);
      weights_q.side   <= WEIGHT_W'(WSIDE_RESET);
      weights_q.corner <= WEIGHT_W'(WCORNER_RESET);
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      weights_q <= weights_d;
    end
  end

  assign eff_width_o  = width_q;
  assign eff_height_o = height_q;
  assign weights_o    = weights_q;

endmodule
`default_nettype wire

[rtl/gb3_window.sv]
// Line stores, 3x3 window and neighbor sums.
`default_nettype none
module gb3_window #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned ColW = $clog2(MAX_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_accept_i,
  input  logic [gb3_pkg::PIXEL_W-1:0]   in_pixel_i,
  input  logic [ColW-1:0]               in_col_i,
  input  logic                          in_emit_i,
  input  gb3_pkg::tag_t                 in_tag_i,
  output logic                          in_ready_o,
  output logic                          sums_valid_o,
  output gb3_pkg::sums_t                sums_o,
  input  logic                          sums_ready_i
);
  import gb3_pkg::*;

  logic               s1_valid_q, s1_valid_d;
  logic [PIXEL_W-1:0] s1_pixel_q;
  logic [ColW-1:0]    s1_col_q;
  logic               s1_emit_q;
  tag_t               s1_tag_q;
  logic               s1_go;

  logic [2*PIXEL_W-1:0] line_rdata;
  logic [PIXEL_W-1:0]   top, mid;

  // Window columns: 1 = left, 2 = middle; rows 0 = top, 2 = current.
  logic [PIXEL_W-1:0] win1_q [3];
  logic [PIXEL_W-1:0] win2_q [3];

  assign s1_go      = s1_valid_q && (!s1_emit_q || sums_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      s1_pixel_q <= in_pixel_i;
      s1_col_q   <= in_col_i;
      s1_emit_q  <= in_emit_i;
      s1_tag_q   <= in_tag_i;
    end
  end

  // Both line stores share one entry: upper byte two rows up, lower byte one row up.
  gb3_ram #(
    .DATA_W (2 * PIXEL_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i ({mid, s1_pixel_q}),
    .re_i    (in_accept_i),
    .raddr_i (in_col_i),
    .rdata_o (line_rdata)
  );

  assign top = line_rdata[2*PIXEL_W-1:PIXEL_W];
  assign mid = line_rdata[PIXEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win1_q[i] <= '0;
        win2_q[i] <= '0;
      end
    end else if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        win1_q[i] <= win2_q[i];
      end
      win2_q[0] <= top;
      win2_q[1] <= mid;
      win2_q[2] <= s1_pixel_q;
    end
  end

  // Sums over the two stored window columns and the incoming column.
  always_comb begin
    sums_o.tag     = s1_tag_q;
    sums_o.center  = win2_q[1];
    sums_o.sides   = SUM_W'(win2_q[0]) + SUM_W'(win2_q[2]) + SUM_W'(win1_q[1]) + SUM_W'(mid);
    sums_o.corners = SUM_W'(win1_q[0]) + SUM_W'(top) + SUM_W'(win1_q[2]) + SUM_W'(s1_pixel_q);
  end

  assign sums_valid_o = s1_valid_q && s1_emit_q;

endmodule
`default_nettype wire

[rtl/gb3_mac.sv]
// Weighting, rounding and saturation pipeline with the output register.
`default_nettype none
module gb3_mac #(
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sums_valid_i,
  output logic                              sums_ready_o,
  input  gb3_pkg::sums_t                    sums_i,
  input  gb3_pkg::weights_t                 weights_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gb3_pkg::TDATA_OUT_W-1:0]   out_data_o,
  output logic                              out_last_o
);
  import gb3_pkg::*;

  localparam int unsigned ProdCW = PIXEL_W + WEIGHT_W;
  localparam int unsigned ProdSW = SUM_W + WEIGHT_W;
  localparam int unsigned AccW   = ProdSW + 2;
  localparam int unsigned RndW   = AccW + 1;
  localparam int unsigned Shift  = WEIGHT_BITS - PIXEL_W;

  logic        s2_valid_q, s3_valid_q, out_valid_q;
  logic        s2_ready, s3_ready, out_ready;
  sums_t       s2_q;
  tag_t        s3_tag_q;
  logic [ProdCW-1:0] prod_c_q;
  logic [ProdSW-1:0] prod_s_q, prod_k_q;
  logic [AccW-1:0]   acc;
  logic [RndW-1:0]   scaled;
  logic [BLUR_W-1:0] blurred;
  logic [TDATA_OUT_W-1:0] out_data_q;
  logic        out_last_q;

  assign out_ready    = !out_valid_q || out_ready_i;
  assign s3_ready     = !s3_valid_q || out_ready;
  assign s2_ready     = !s2_valid_q || s3_ready;
  assign sums_ready_o = s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= sums_valid_i;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  assign acc = AccW'(prod_c_q) + AccW'(prod_s_q) + AccW'(prod_k_q);

  if (Shift > 0) begin : g_round
    logic [RndW-1:0] rounded;
    assign rounded = RndW'(acc) + (RndW'(1) << (Shift - 1));
    assign scaled  = rounded >> Shift;
  end else begin : g_plain
    assign scaled = RndW'(acc);
  end

  assign blurred = (scaled > RndW'({BLUR_W{1'b1}})) ? {BLUR_W{1'b1}} : BLUR_W'(scaled);

  always_ff @(posedge clk_i) begin
    if (s2_ready && sums_valid_i) begin
      s2_q <= sums_i;
    end
    if (s3_ready && s2_valid_q) begin
      s3_tag_q <= s2_q.tag;
      prod_c_q <= ProdCW'(s2_q.center) * ProdCW'(weights_i.center);
      prod_s_q <= ProdSW'(s2_q.sides) * ProdSW'(weights_i.side);
      prod_k_q <= ProdSW'(s2_q.corners) * ProdSW'(weights_i.corner);
    end
    if (out_ready && s3_valid_q) begin
      out_data_q <= {{TDATA_PAD_W{1'b0}}, s3_tag_q.col, s3_tag_q.row, blurred};
      out_last_q <= s3_tag_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

[rtl/gaussian_blur_3x3_unit.sv]
// Top level of the streaming 3x3 Gaussian blur unit.
// Takes one 8-bit pixel per clock in raster order and returns, for every interior pixel,
// the Q8.8 blurred value with its row, column and a frame-last flag in tlast; border
// pixels consume an input item and give no output item. Throughput is one pixel per
// cycle: the line-store RAM has separate read and write ports, is read when a pixel is
// taken and written back when the pixel leaves the window stage, and every stage can hand
// on its item in each cycle. A taken item passes the window stage, the neighbor-sum
// register and the product register, then the weighted sum, rounding and saturation
// go into the output register. An output stall holds the pipeline through a
// combinational ready path; only border pixels, which give no output item, still
// leave the window stage. Line stores are not cleared after reset, so the first two
// rows of a frame fill them before any output item depends on them. Write configuration
// only while the unit is idle; size registers are clamped to 3..MAX_WIDTH and 3..4095.
`default_nettype none
module gaussian_blur_3x3_unit #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gb3_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [gb3_pkg::WEIGHT_W-1:0]        cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gb3_pkg::PIXEL_W-1:0]         s_axis_tdata,  // [7:0] pixel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] blurred, [27:16] out_row, [37:28] out_col, [39:38] zero
  output logic [gb3_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast   // frame_last
);
  import gb3_pkg::*;

  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned WidthW = $clog2(MAX_WIDTH + 1);

  logic [WidthW-1:0]  eff_width;
  logic [IMG_H_W-1:0] eff_height;
  weights_t           weights;

  logic [ColW-1:0]   col_q, col_d, col_m1;
  logic [ROW_W-1:0]  row_q, row_d, row_inc;
  logic [WidthW-1:0] col_inc;
  logic              s_accept, emit_in, last_in;
  tag_t              in_tag;

  logic  sums_valid, sums_ready;
  sums_t sums;

  gb3_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .eff_width_o  (eff_width),
    .eff_height_o (eff_height),
    .weights_o    (weights)
  );

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign col_inc  = WidthW'(col_q) + WidthW'(1);
  assign row_inc  = row_q + ROW_W'(1);
  assign emit_in  = (row_q >= ROW_W'(2)) && (col_q >= ColW'(2));
  assign last_in  = (row_inc == eff_height) && (col_inc == eff_width);
  assign col_m1   = col_q - ColW'(1);

  always_comb begin
    in_tag.last = last_in;
    in_tag.row  = row_q - ROW_W'(1);
    in_tag.col  = OUTCOL_W'(col_m1);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (s_accept) begin
      if (col_inc >= eff_width) begin
        col_d = '0;
        row_d = (row_inc >= eff_height) ? '0 : row_inc;
      end else begin
        col_d = ColW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  gb3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (s_accept),
    .in_pixel_i   (s_axis_tdata),
    .in_col_i     (col_q),
    .in_emit_i    (emit_in),
    .in_tag_i     (in_tag),
    .in_ready_o   (s_axis_tready),
    .sums_valid_o (sums_valid),
    .sums_o       (sums),
    .sums_ready_i (sums_ready)
  );

  gb3_mac #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sums_valid_i (sums_valid),
    .sums_ready_o (sums_ready),
    .sums_i       (sums),
    .weights_i    (weights),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MAX_WIDTH)
    else $error("column counter beyond line store depth");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < ROW_W'(4095))
    else $error("row counter beyond frame limit");

  a_last_is_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && last_in |-> emit_in)
    else $error("frame-last flag on a border pixel");

  a_width_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eff_width >= WidthW'(DIM_MIN)) && (32'(eff_width) <= MAX_WIDTH))
    else $error("effective width out of range");

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench of the streaming 3x3 Gaussian blur unit.
module tb;
  import gb3_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned MAX_H        = 4095;
  localparam int unsigned ROUND_SHIFT  = WEIGHT_W - 8;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    logic [BLUR_W-1:0]   blurred;
    logic [ROW_W-1:0]    row;
    logic [OUTCOL_W-1:0] col;
    logic                last;
  } blur_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  cfg_index_e             cfg_index_i   = CFG_IMAGE_WIDTH;
  logic [WEIGHT_W-1:0]    cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIXEL_W-1:0]     s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int unsigned src_idle_pct   = 8;
  int unsigned sink_stall_pct = 48;
  int unsigned error_count    = 0;
  int unsigned pixels_sent    = 0;

  // Predictor state and its copy of the registers
  logic [IMG_W_W-1:0]  width_reg   = IMG_W_W'(WIDTH_RESET);
  logic [IMG_H_W-1:0]  height_reg  = IMG_H_W'(HEIGHT_RESET);
  logic [WEIGHT_W-1:0] w_center    = WEIGHT_W'(WCENTER_RESET);
  logic [WEIGHT_W-1:0] w_side      = WEIGHT_W'(WSIDE_RESET);
  logic [WEIGHT_W-1:0] w_corner    = WEIGHT_W'(WCORNER_RESET);
  bit [PIXEL_W-1:0]    row_up1 [MAX_W];
  bit [PIXEL_W-1:0]    row_up2 [MAX_W];
  bit [PIXEL_W-1:0]    win [3][3];
  int unsigned         col_q = 0;
  int unsigned         row_q = 0;

  blur_result_t pending_blur_q[$];
  blur_result_t got_blur;

  gaussian_blur_3x3_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clamp_dim(width_reg, MAX_W);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_dim(height_reg, MAX_H);
  endfunction

  function automatic logic [BLUR_W-1:0] blur_of_window();
    int unsigned     sides;
    int unsigned     corners;
    longint unsigned acc;
    sides   = 32'(win[0][1]) + 32'(win[2][1]) + 32'(win[1][0]) + 32'(win[1][2]);
    corners = 32'(win[0][0]) + 32'(win[0][2]) + 32'(win[2][0]) + 32'(win[2][2]);
    acc = 64'(win[1][1]) * 64'(w_center) + 64'(sides) * 64'(w_side)
        + 64'(corners) * 64'(w_corner);
    if (ROUND_SHIFT > 0) acc = (acc + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (acc > 64'd65535) acc = 64'd65535;
    return BLUR_W'(acc);
  endfunction

  function automatic void predict_blur(logic [PIXEL_W-1:0] px);
    int unsigned  w;
    int unsigned  h;
    bit [7:0]     top;
    bit [7:0]     mid;
    blur_result_t res;
    w   = eff_width();
    h   = eff_height();
    top = row_up2[col_q];
    mid = row_up1[col_q];
    row_up2[col_q] = mid;
    row_up1[col_q] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (row_q >= 2 && col_q >= 2) begin
      res.blurred = blur_of_window();
      res.row     = ROW_W'(row_q - 1);
      res.col     = OUTCOL_W'(col_q - 1);
      res.last    = (row_q == h - 1) && (col_q == w - 1);
      pending_blur_q.push_back(res);
    end
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
      if (row_q >= h) row_q = 0;
    end
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return PIXEL_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    if ($urandom_range(3) == 0) return WEIGHT_W'($urandom_range(65535));
    return WEIGHT_W'($urandom_range(16383));
  endfunction

  task automatic send_pixel(logic [PIXEL_W-1:0] px);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_blur(px);
    pixels_sent++;
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // Run the counters back to the start of a frame, or through a whole one
  task automatic send_frame();
    do send_pixel(rand_pixel());
    while (col_q != 0 || row_q != 0);
  endtask

  task automatic cfg_write(cfg_index_e idx, logic [WEIGHT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_IMAGE_WIDTH:   width_reg  = val[IMG_W_W-1:0];
      CFG_IMAGE_HEIGHT:  height_reg = val[IMG_H_W-1:0];
      CFG_WEIGHT_CENTER: w_center   = val;
      CFG_WEIGHT_SIDE:   w_side     = val;
      CFG_WEIGHT_CORNER: w_corner   = val;
      default: ;
    endcase
  endtask

  task automatic set_weights(logic [WEIGHT_W-1:0] wc, logic [WEIGHT_W-1:0] ws,
                             logic [WEIGHT_W-1:0] wk);
    cfg_write(CFG_WEIGHT_CENTER, wc);
    cfg_write(CFG_WEIGHT_SIDE, ws);
    cfg_write(CFG_WEIGHT_CORNER, wk);
  endtask

  task automatic set_size(logic [WEIGHT_W-1:0] w, logic [WEIGHT_W-1:0] h);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    @(posedge clk_i);
    while (pending_blur_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_blur_q.size() == 0) begin
        $error("unexpected item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        got_blur = pending_blur_q.pop_front();
        if (m_axis_tdata[15:0] !== got_blur.blurred) begin
          $error("blurred: expected %0d, got %0d", got_blur.blurred, m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[27:16] !== got_blur.row) begin
          $error("out_row: expected %0d, got %0d", got_blur.row, m_axis_tdata[27:16]);
          error_count++;
        end
        if (m_axis_tdata[37:28] !== got_blur.col) begin
          $error("out_col: expected %0d, got %0d", got_blur.col, m_axis_tdata[37:28]);
          error_count++;
        end
        if (m_axis_tlast !== got_blur.last) begin
          $error("frame_last: expected %0d, got %0d", got_blur.last, m_axis_tlast);
          error_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Reset width and weights, with the height register's upper bits masked off
  task automatic test_reset_width_and_weights();
    wait_idle();
    send_pixels(40);
    wait_idle();
    cfg_write(CFG_IMAGE_HEIGHT, 16'hF003);
    cfg_write(CFG_IMAGE_WIDTH, 16'd8);
    send_frame();
  endtask

  task automatic test_size_clamp();
    logic [WEIGHT_W-1:0] narrow [4];
    narrow = '{16'd0, 16'd1, 16'd2, 16'hF803};
    foreach (narrow[i]) begin
      wait_idle();
      set_size(narrow[i], narrow[3 - i] & 16'hF00F);
      send_frame();
    end
    wait_idle();
    set_size(16'd2047, 16'd3);
    send_pixels(40);
    wait_idle();
    cfg_write(CFG_IMAGE_WIDTH, 16'd6);
    send_frame();
    wait_idle();
    set_size(16'd3, 16'd4095);
    send_pixels(30);
    wait_idle();
    cfg_write(CFG_IMAGE_HEIGHT, 16'd3);
    send_frame();
  endtask

  task automatic test_pixel_extremes();
    wait_idle();
    set_size(16'd5, 16'd4);
    set_weights(16'd13380, 16'd8116, 16'd4922);
    for (int i = 0; i < 20; i++) begin
      if (i < 10) send_pixel(i[0] ? 8'hFF : 8'h00);
      else send_pixel(i[0] ? 8'hAA : 8'h55);
    end
    wait_idle();
    set_size(16'd3, 16'd3);
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (9) send_pixel(8'hFF);
    wait_idle();
    set_weights(16'd0, 16'd0, 16'd0);
    repeat (9) send_pixel(8'hFF);
    wait_idle();
    set_weights(16'hFFFF, 16'd0, 16'd0);
    send_frame();
  endtask

  task automatic test_midframe_update();
    wait_idle();
    set_size(16'd8, 16'd6);
    set_weights(16'd20000, 16'd6000, 16'd3000);
    send_pixels(20);
    wait_idle();
    cfg_write(CFG_WEIGHT_CENTER, 16'd40000);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd3);
    send_frame();
    wait_idle();
    cfg_write(CFG_IMAGE_HEIGHT, 16'd6);
    send_pixels(22);
    wait_idle();
    cfg_write(CFG_IMAGE_WIDTH, 16'd4);
    send_frame();
  endtask

  task automatic test_random_frames(int unsigned n_items);
    int unsigned start;
    int unsigned cut;
    start = pixels_sent;
    while (pixels_sent - start < n_items) begin
      wait_idle();
      set_size(WEIGHT_W'($urandom_range(14)), WEIGHT_W'($urandom_range(8)));
      set_weights(rand_weight(), rand_weight(), rand_weight());
      cut = ($urandom_range(7) == 0) ? $urandom_range(eff_width() * eff_height() - 1, 1) : 0;
      if (cut != 0) begin
        send_pixels(cut);
        wait_idle();
        cfg_write(CFG_WEIGHT_CENTER, rand_weight());
        cfg_write(CFG_IMAGE_HEIGHT, WEIGHT_W'($urandom_range(8)));
        if ($urandom_range(1) == 0)
          cfg_write(CFG_IMAGE_WIDTH, WEIGHT_W'($urandom_range(eff_width(), DIM_MIN)));
      end
      send_frame();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_width_and_weights();
    test_size_clamp();
    test_pixel_extremes();
    test_midframe_update();
    test_random_frames(240);
    src_idle_pct   = 48;
    sink_stall_pct = 8;
    test_random_frames(240);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_frames(240);
    wait_idle();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
